// File: design/wsd_pkg.sv
// Shared types and constants of the weight stability detector.
// No dependencies; compile this file first.
package wsd_pkg;

	localparam int SAMPLE_W   = 25;
	localparam int JIT_W      = 24;
	localparam int MINREP_W   = 24;
	localparam int MINCHG_W   = 25;
	localparam int GAP_W      = 8;
	localparam int CNT_W      = 8;
	localparam int CFG_DATA_W = 25;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_JITTER     = 2'd0,
		REG_MIN_REPORT = 2'd1,
		REG_MIN_CHANGE = 2'd2,
		REG_MIN_GAP    = 2'd3
	} cfg_idx_t;

	localparam logic [JIT_W-1:0]    JITTER_RST     = JIT_W'(160);
	localparam logic [MINREP_W-1:0] MIN_REPORT_RST = MINREP_W'(8000);
	localparam logic [MINCHG_W-1:0] MIN_CHANGE_RST = MINCHG_W'(8000);
	localparam logic [GAP_W-1:0]    MIN_GAP_RST    = GAP_W'(10);
	localparam logic [CNT_W-1:0]    CNT_MAX        = '1;

endpackage

// File: design/wsd_if.sv
// Handshake channels of the weight stability detector: samples, reports, config.
// Depends on wsd_pkg.
interface wsd_sample_if;
	logic              valid;
	logic              ready;
	wsd_pkg::sample_t  weight_sample;

	modport source (output valid, output weight_sample, input ready);
	modport sink   (input valid, input weight_sample, output ready);
endinterface

interface wsd_report_if;
	logic              valid;
	logic              ready;
	wsd_pkg::sample_t  report_average;
	logic              new_weight;

	modport source (output valid, output report_average, output new_weight, input ready);
	modport sink   (input valid, input report_average, input new_weight, output ready);
endinterface

interface wsd_cfg_if;
	logic                                valid;
	logic                                ready;
	wsd_pkg::cfg_idx_t                   index;
	logic [wsd_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/wsd_cell.sv
// One window cell: holds one sample, passes it on to the next cell on a shift,
// and flags it when it strays too far from the window mean. Depends on wsd_pkg.
module wsd_cell #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift,
	input  wsd_pkg::sample_t        d,
	output wsd_pkg::sample_t        q,
	input  logic signed [wsd_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] sum,
	input  logic [wsd_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH):0]          lim,
	output logic                    unstable
);
	import wsd_pkg::*;

	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int DIFF_W = SUM_W + 1;
	localparam logic signed [DIFF_W-1:0] DEPTH_S = DIFF_W'(WINDOW_DEPTH);

	sample_t                   entry_q;
	logic signed [DIFF_W-1:0]  scaled;
	logic signed [DIFF_W-1:0]  diff;
	logic [DIFF_W-1:0]         mag;

	// advance the window by one place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

	// distance of depth*entry from the window sum
	always_comb begin
		scaled   = DIFF_W'(entry_q) * DEPTH_S;
		diff     = DIFF_W'(sum) - scaled;
		mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		unstable = mag > lim;
	end

endmodule

// File: design/wsd_div.sv
// Three-stage divider by a constant: reciprocal multiply, remainder, correction.
// Gives the quotient truncated toward zero. Depends on wsd_pkg.
module wsd_div #(
	parameter int IN_W    = 28,
	parameter int DIVISOR = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [IN_W-1:0]  rsum,
	output wsd_pkg::sample_t        avg,
	output logic                    done
);
	import wsd_pkg::*;

	localparam int                 SHIFT   = IN_W;
	localparam int                 PROD_W  = IN_W + SHIFT + 1;
	localparam longint unsigned    RECIP_L = (64'd1 << SHIFT) / DIVISOR;
	localparam logic [SHIFT:0]     RECIP   = RECIP_L[SHIFT:0];
	localparam logic [IN_W-1:0]    DIV_U   = IN_W'(DIVISOR);

	logic [IN_W-1:0]    mag;
	logic [IN_W-1:0]    q_est;
	logic [IN_W-1:0]    q_fix;
	logic [IN_W-1:0]    q_signed;

	logic               v_s1, v_s2;
	logic               neg_s1, neg_s2;
	logic [IN_W-1:0]    mag_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [IN_W-1:0]    q_s2, r_s2;
	sample_t            avg_q;
	logic               done_q;

	always_comb begin
		mag      = rsum[IN_W-1] ? IN_W'(-rsum) : IN_W'(rsum);
		q_est    = prod_s1[SHIFT +: IN_W];
		q_fix    = (r_s2 >= DIV_U) ? q_s2 + IN_W'(1) : q_s2;
		q_signed = neg_s2 ? IN_W'(-q_fix) : q_fix;
	end

	// hold the valid marks; done stays up until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			if (start) begin
				done_q <= 1'b0;
			end else if (v_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	// multiply by the reciprocal, take the remainder, correct by one
	always_ff @(posedge clk) begin
		if (start) begin
			neg_s1  <= rsum[IN_W-1];
			mag_s1  <= mag;
			prod_s1 <= PROD_W'(mag) * PROD_W'(RECIP);
		end
		if (v_s1) begin
			neg_s2 <= neg_s1;
			q_s2   <= q_est;
			r_s2   <= mag_s1 - IN_W'(q_est * DIV_U);
		end
		if (v_s2) begin
			avg_q <= SAMPLE_W'(q_signed);
		end
	end

	assign avg  = avg_q;
	assign done = done_q;

endmodule

// File: design/weight_stability_detector_top.sv
// Weight stability detector: window of cells, running sums, divider, report logic.
// Depends on wsd_pkg, wsd_if, wsd_cell and wsd_div.
//
//  channel   dir  payload                          request taken when
//  samples   in   weight_sample                    valid & ready
//  reports   out  report_average, new_weight       valid & ready
//  cfg       in   index, data                      valid & ready (ready held high)
//
// Steps of one item with no stall at the output: acceptance (window shift and
// running sums), the cell compares, then the three register stages of the
// reciprocal divider, whose result is then taken into the output register.
// Reset: window, sums, held weight and counter clear; registers take defaults.
// Stalls: a finished report waits in the output register while the next sample
// is taken; a second report then waits in the divider until the first is gone.
module weight_stability_detector_top #(
	parameter int WINDOW_DEPTH   = 10,
	parameter int IGNORED_OLDEST = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	wsd_sample_if.sink     samples,
	wsd_report_if.source   reports,
	wsd_cfg_if.sink        cfg
);
	import wsd_pkg::*;

	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int DIFF_W = SUM_W + 1;
	localparam int COUNT  = (WINDOW_DEPTH - IGNORED_OLDEST < 1) ? 1
	                        : WINDOW_DEPTH - IGNORED_OLDEST;
	localparam int RSUM_W = SAMPLE_W + $clog2(COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_WAIT
	} state_t;

	state_t                   state_q;
	logic [JIT_W-1:0]         jitter_q;
	logic [MINREP_W-1:0]      minrep_q;
	logic [MINCHG_W-1:0]      minchg_q;
	logic [GAP_W-1:0]         gap_q;

	sample_t                  win [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]  unstable;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [RSUM_W-1:0] rsum_q;
	logic [DIFF_W-1:0]        lim;
	sample_t                  held_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     stable_q;

	logic                     accept;
	logic                     finish;
	logic                     report;
	logic signed [SAMPLE_W:0] hdiff;
	logic [SAMPLE_W:0]        hmag;
	logic                     hclear;
	sample_t                  avg;
	logic                     div_done;

	logic                     out_valid_q;
	sample_t                  out_avg_q;
	logic                     out_new_q;

	// take register writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_q <= JITTER_RST;
			minrep_q <= MIN_REPORT_RST;
			minchg_q <= MIN_CHANGE_RST;
			gap_q    <= MIN_GAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_JITTER:     jitter_q <= cfg.data[JIT_W-1:0];
				REG_MIN_REPORT: minrep_q <= cfg.data[MINREP_W-1:0];
				REG_MIN_CHANGE: minchg_q <= cfg.data[MINCHG_W-1:0];
				REG_MIN_GAP:    gap_q    <= cfg.data[GAP_W-1:0];
			endcase
		end
	end

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);
	assign lim           = DIFF_W'(jitter_q) * DIFF_W'(WINDOW_DEPTH);

	// row of window cells, newest at cell zero
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			wsd_cell #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (accept),
				.d        (samples.weight_sample),
				.q        (win[i]),
				.sum      (sum_q),
				.lim      (lim),
				.unstable (unstable[i])
			);
		end else begin : g_tail
			wsd_cell #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (accept),
				.d        (win[i-1]),
				.q        (win[i]),
				.sum      (sum_q),
				.lim      (lim),
				.unstable (unstable[i])
			);
		end
	end

	wsd_div #(.IN_W(RSUM_W), .DIVISOR(COUNT)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_CMP),
		.rsum   (rsum_q),
		.avg    (avg),
		.done   (div_done)
	);

	// drop the held weight when the sample moves too far from it
	always_comb begin
		hdiff  = (SAMPLE_W+1)'(samples.weight_sample) - (SAMPLE_W+1)'(held_q);
		hmag   = hdiff[SAMPLE_W] ? (SAMPLE_W+1)'(-hdiff) : (SAMPLE_W+1)'(hdiff);
		hclear = hmag > (SAMPLE_W+1)'(minchg_q);
	end

	// decide on a report once the mean is ready and the output has room
	assign finish = (state_q == ST_WAIT) && div_done && (!out_valid_q || reports.ready);
	assign report = stable_q
	                && ($signed((SAMPLE_W+1)'(avg)) > $signed((SAMPLE_W+1)'(minrep_q)))
	                && (cnt_q > gap_q)
	                && (held_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			rsum_q      <= '0;
			held_q      <= '0;
			cnt_q       <= '0;
			stable_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_avg_q   <= '0;
			out_new_q   <= 1'b0;
		end else begin
			if (out_valid_q && reports.ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sum_q  <= sum_q + SUM_W'(samples.weight_sample)
						          - SUM_W'(win[WINDOW_DEPTH-1]);
						rsum_q <= rsum_q + RSUM_W'(samples.weight_sample)
						          - RSUM_W'(win[COUNT-1]);
						if (hclear) begin
							held_q <= '0;
						end
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					stable_q <= ~|unstable;
					state_q  <= ST_WAIT;
				end
				ST_WAIT: begin
					if (finish) begin
						if (report) begin
							held_q <= avg;
						end
						if (stable_q) begin
							cnt_q <= CNT_W'(1);
						end else if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						out_valid_q <= 1'b1;
						out_avg_q   <= avg;
						out_new_q   <= report;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign reports.valid          = out_valid_q;
	assign reports.report_average = out_avg_q;
	assign reports.new_weight     = out_new_q;

	a_report_above_min: assert property (@(posedge clk) disable iff (!arst_n)
		reports.valid && reports.new_weight |->
		$signed((SAMPLE_W+1)'(reports.report_average)) > $signed((SAMPLE_W+1)'(minrep_q)))
		else $error("reported weight not above minimum");

	a_held_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		finish && report |=> held_q != '0)
		else $error("held weight empty after a report");

	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		finish && stable_q |=> cnt_q == CNT_W'(1))
		else $error("readings counter did not restart on a stable window");

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> ##3 div_done)
		else $error("divider result late");

endmodule
